>>> sv/nearest_palette_color_defines.svh
// ----------------------------------------------------------------------------
// nearest_palette_color_defines
// Assertion macros for the palette search block; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef NEAREST_PALETTE_COLOR_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_DEFINES_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define NPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nearest_palette_color: assertion failed");
// antecedent implies consequent in the next cycle
`define NPC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nearest_palette_color: assertion failed");
`else
`define NPC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define NPC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> sv/npc_pkg.sv
// ----------------------------------------------------------------------------
// npc_pkg
// Shared types and constants of the nearest palette colour search.
// ----------------------------------------------------------------------------
`default_nettype none

package npc_pkg;

  localparam int unsigned PALETTE_DEPTH_DEF = 256;
  localparam int unsigned INDEX_LIMIT       = 256;

  localparam int unsigned CW = 8;   // colour component width
  localparam int unsigned IW = 8;   // palette index width
  localparam int unsigned DW = 18;  // squared distance width

  localparam logic [DW-1:0] MAX_DIST = 18'd195075;

  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  // one distance result from the shared unit
  typedef struct packed {
    logic          valid;
    logic [IW-1:0] idx;
    logic [DW-1:0] dist_sq;
  } npc_dist_t;

endpackage

`default_nettype wire

>>> sv/npc_palette_mem.sv
// ----------------------------------------------------------------------------
// npc_palette_mem
// Palette store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module npc_palette_mem #(
  parameter  int unsigned DEPTH = 256,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [23:0]   wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [23:0]   rd_data
);

  logic [23:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> sv/npc_dist_unit.sv
// ----------------------------------------------------------------------------
// npc_dist_unit
// Shared squared-distance pipeline: absolute differences, squares, sum.
// ----------------------------------------------------------------------------
`default_nettype none

module npc_dist_unit (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic [npc_pkg::IW-1:0]    in_idx,
  input  wire logic [23:0]               entry,
  input  wire logic [23:0]               pixel,
  output logic                           busy,
  output npc_pkg::npc_dist_t             res
);

  import npc_pkg::*;

  logic          s1_valid_r;
  logic [IW-1:0] s1_idx_r;
  logic [CW-1:0] s1_dr_r, s1_dg_r, s1_db_r;
  logic          s2_valid_r;
  logic [IW-1:0] s2_idx_r;
  logic [15:0]   s2_sr_r, s2_sg_r, s2_sb_r;
  logic          s3_valid_r;
  logic [IW-1:0] s3_idx_r;
  logic [DW-1:0] s3_dist_r;

  function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r  <= in_idx;
    s1_dr_r   <= abs_diff(entry[23:16], pixel[23:16]);
    s1_dg_r   <= abs_diff(entry[15:8],  pixel[15:8]);
    s1_db_r   <= abs_diff(entry[7:0],   pixel[7:0]);
    s2_idx_r  <= s1_idx_r;
    s2_sr_r   <= {8'd0, s1_dr_r} * {8'd0, s1_dr_r};
    s2_sg_r   <= {8'd0, s1_dg_r} * {8'd0, s1_dg_r};
    s2_sb_r   <= {8'd0, s1_db_r} * {8'd0, s1_db_r};
    s3_idx_r  <= s2_idx_r;
    s3_dist_r <= DW'(s2_sr_r) + DW'(s2_sg_r) + DW'(s2_sb_r);
  end

  assign busy = s1_valid_r | s2_valid_r;
  assign res  = {s3_valid_r, s3_idx_r, s3_dist_r};

endmodule

`default_nettype wire

>>> sv/nearest_palette_color.sv
// ----------------------------------------------------------------------------
// nearest_palette_color
// Nearest palette colour search by squared RGB distance, one entry a cycle.
// ----------------------------------------------------------------------------
//  channel | direction | tdata (low bit up)                       | tuser
//  in_     | slave     | entry_index, red, green, blue (32 bits)  | operation
//  out_    | master    | palette_index, best_distance, pad (32)   | -
//  cfg_    | slave     | palette_size (9 bits)                    | -
//
//  After a load the block is ready for the next item straight away.
//  A classify reads N = min(palette_size, PALETTE_DEPTH, 256) entries, one per
//  cycle, through the single read port of the palette memory into the distance
//  pipeline, skipping the reads for an empty palette; once the pipeline has
//  drained, out_tvalid is raised when the output register is free.
//  Reset clears palette_size to 0; palette contents are undefined until loaded.
//  A result waits in the output register; in_tready stays low from a classify
//  transfer until its result has entered that register.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_palette_color #(
  parameter int unsigned PALETTE_DEPTH = npc_pkg::PALETTE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // entry_index, red, green, blue
  input  wire logic        in_tuser,   // operation
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata,  // palette_index, best_distance, zero pad
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [8:0]  cfg_data    // palette_size
);

  import npc_pkg::*;

  localparam int unsigned AW  = $clog2(PALETTE_DEPTH);
  localparam int unsigned CNW = ((AW > IW) ? AW : IW) + 1;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]     state_r, state_nxt;
  logic [8:0]     palette_size_r;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic [CNW-1:0] lim_r, lim_nxt;
  logic [23:0]    pix_r;
  logic           rd_valid_r;
  logic [IW-1:0]  rd_idx_r;
  logic [23:0]    rd_data;
  logic           found_r;
  logic [IW-1:0]  best_idx_r;
  logic [DW-1:0]  best_r;
  logic           out_tvalid_r;
  logic [IW-1:0]  out_idx_r;
  logic [DW-1:0]  out_dist_r;

  logic           in_xfer, wr_en, rd_en, busy, pipe_empty, out_load;
  logic [CNW-1:0] wr_ext, depth_c, size_ext, lim_a;
  npc_dist_t      res;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  // search length: saturate at store depth and at what an 8-bit index names
  assign depth_c  = CNW'(PALETTE_DEPTH);
  assign size_ext = CNW'(palette_size_r);
  assign lim_a    = (size_ext > depth_c) ? depth_c : size_ext;
  assign lim_nxt  = (lim_a > CNW'(INDEX_LIMIT)) ? CNW'(INDEX_LIMIT) : lim_a;

  assign wr_ext = CNW'(in_tdata[7:0]);
  assign wr_en  = in_xfer && (in_tuser == OP_LOAD) && (wr_ext < depth_c);
  assign rd_en  = (state_r == ST_SCAN);

  assign pipe_empty = !rd_valid_r && !busy && !res.valid;
  assign out_load   = (state_r == ST_FINISH) && (!out_tvalid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer && (in_tuser == OP_CLASSIFY)) begin
          cnt_nxt   = '0;
          state_nxt = (lim_nxt == '0) ? ST_DRAIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_nxt == lim_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      palette_size_r <= '0;
      rd_valid_r     <= 1'b0;
      out_tvalid_r   <= 1'b0;
      found_r        <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rd_valid_r <= rd_en;
      if (cfg_valid && cfg_ready) begin
        palette_size_r <= cfg_data;
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (in_xfer && (in_tuser == OP_CLASSIFY)) begin
        found_r <= 1'b0;
      end else if (res.valid) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    rd_idx_r <= cnt_r[IW-1:0];
    if (in_xfer && (in_tuser == OP_CLASSIFY)) begin
      lim_r      <= lim_nxt;
      pix_r      <= in_tdata[31:8];
      best_r     <= MAX_DIST;
      best_idx_r <= '0;
    end else if (res.valid && (!found_r || (res.dist_sq < best_r))) begin
      // strict compare keeps the first index on ties
      best_r     <= res.dist_sq;
      best_idx_r <= res.idx;
    end
    if (out_load) begin
      out_idx_r  <= best_idx_r;
      out_dist_r <= best_r;
    end
  end

  npc_palette_mem #(
    .DEPTH (PALETTE_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_ext[AW-1:0]),
    .wr_data (in_tdata[31:8]),
    .rd_en   (rd_en),
    .rd_addr (cnt_r[AW-1:0]),
    .rd_data (rd_data)
  );

  npc_dist_unit u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (rd_valid_r),
    .in_idx   (rd_idx_r),
    .entry    (rd_data),
    .pixel    (pix_r),
    .busy     (busy),
    .res      (res)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {6'd0, out_dist_r, out_idx_r};

`include "nearest_palette_color_defines.svh"

  `NPC_ASSERT_NXT(a_classify_starts, clk, rst_n, in_xfer && (in_tuser == OP_CLASSIFY),
    (state_r == ST_SCAN) || (state_r == ST_DRAIN))
  `NPC_ASSERT_IMP(a_res_in_search, clk, rst_n, res.valid,
    (state_r == ST_SCAN) || (state_r == ST_DRAIN))
  `NPC_ASSERT_IMP(a_finish_empty, clk, rst_n, state_r == ST_FINISH, pipe_empty)
  `NPC_ASSERT_IMP(a_best_bounded, clk, rst_n, state_r == ST_FINISH, best_r <= MAX_DIST)

endmodule

`default_nettype wire

>>> tb/npc_checker.sv
// ----------------------------------------------------------------------------
// npc_checker
// Watches the input, result and configuration channels of the palette search
// block. Keeps its own palette and search size, works out the nearest entry
// for every accepted pixel, and compares each result transfer field by field
// with the oldest expected match.
// ----------------------------------------------------------------------------
`default_nettype none

module npc_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [31:0] in_tdata,   // entry_index, red, green, blue
  input  wire logic        in_tuser,   // operation
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [31:0] out_tdata,  // palette_index, best_distance, zero pad
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [8:0]  cfg_data,   // palette_size
  output int               mismatches,
  output int               waiting,
  output int               loads_seen,
  output int               lookups_seen,
  output int               results_seen
);

  import npc_pkg::*;

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [IW-1:0] entry;
    logic [DW-1:0] dist_sq;
  } colour_match_t;

  logic [3*CW-1:0] palette_copy [PALETTE_DEPTH_DEF];
  logic [8:0]      search_size;
  colour_match_t   expected_matches [$];

  // lowest entry with the strictly smallest squared distance
  function automatic colour_match_t nearest_match(input logic [CW-1:0] r, g, b);
    colour_match_t best;
    int unsigned   span;
    int unsigned   d;
    int            dr, dg, db;
    best.entry   = '0;
    best.dist_sq = MAX_DIST;
    span = search_size;
    if (span > PALETTE_DEPTH_DEF) span = PALETTE_DEPTH_DEF;
    if (span > INDEX_LIMIT) span = INDEX_LIMIT;
    for (int unsigned j = 0; j < span; j++) begin
      dr = int'(palette_copy[j][23:16]) - int'(r);
      dg = int'(palette_copy[j][15:8]) - int'(g);
      db = int'(palette_copy[j][7:0]) - int'(b);
      d  = dr * dr + dg * dg + db * db;
      if (j == 0 || d < best.dist_sq) begin
        best.entry   = j[IW-1:0];
        best.dist_sq = d[DW-1:0];
      end
    end
    return best;
  endfunction

  task automatic flag_field(input string field, input int unsigned want,
                            input int unsigned got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch in %s: expected %0d, got %0d", field, want, got);
  endtask

  always @(posedge clk) begin : monitor
    colour_match_t want;
    logic [CW-1:0] r, g, b;
    if (!rst_n) begin
      search_size = '0;
      expected_matches.delete();
    end else begin
      if (cfg_valid && cfg_ready) search_size = cfg_data;

      // compare before queuing, so a result and a new pixel on one edge keep order
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_matches.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: entry %0d, distance %0d",
                     out_tdata[7:0], out_tdata[25:8]);
        end else begin
          want = expected_matches.pop_front();
          if (out_tdata[7:0] !== want.entry)
            flag_field("palette_index", want.entry, out_tdata[7:0]);
          if (out_tdata[25:8] !== want.dist_sq)
            flag_field("best_distance", want.dist_sq, out_tdata[25:8]);
          if (out_tdata[31:26] !== '0)
            flag_field("pad", 0, out_tdata[31:26]);
        end
      end

      if (in_tvalid && in_tready) begin
        r = in_tdata[15:8];
        g = in_tdata[23:16];
        b = in_tdata[31:24];
        if (in_tuser == OP_LOAD) begin
          // an 8-bit index always lands inside a 256-deep store
          loads_seen++;
          palette_copy[in_tdata[7:0]] = {r, g, b};
        end else begin
          lookups_seen++;
          expected_matches.push_back(nearest_match(r, g, b));
        end
      end
    end
    waiting = expected_matches.size();
  end

endmodule

`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the nearest palette colour search: a short directed run over
// an empty palette, ties, exact hits and the largest distance, then random
// phases that each set a palette size, load whatever entries the search will
// read, and mix loads with pixel lookups. Both channels idle at random and
// the result side holds off once for a long stretch. npc_checker predicts
// and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import npc_pkg::*;

  localparam int ITEM_TARGET   = 1400;
  localparam int PHASE_ITEMS   = 48;
  localparam int MAX_GAP       = 17;
  localparam int HOLD_AT       = 100;
  localparam int HOLD_CYCLES   = 1500;
  localparam int SETTLE_CYCLES = 16;
  localparam int IDLE_LIMIT    = 20000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;   // entry_index, red, green, blue
  logic        in_tuser   = 1'b0; // operation
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // palette_index, best_distance, zero pad
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [8:0]  cfg_data   = '0;   // palette_size

  int chk_mismatches, chk_waiting, chk_loads, chk_lookups, chk_results;

  logic [23:0] colour_shadow [256];
  bit          loaded        [256];
  int          items_sent;
  int          sizes_written;
  int          quiet_cycles;
  bit          burst;

  nearest_palette_color i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  npc_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .mismatches   (chk_mismatches),
    .waiting      (chk_waiting),
    .loads_seen   (chk_loads),
    .lookups_seen (chk_lookups),
    .results_seen (chk_results)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // keep tvalid high across back-to-back items; lower it only for a gap
  task automatic offer_item(input logic op, input logic [7:0] idx,
                            input logic [7:0] r, g, b);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {b, g, r, idx};
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    items_sent++;
    if (op == OP_LOAD) begin
      colour_shadow[idx] = {r, g, b};
      loaded[idx]        = 1'b1;
    end
  endtask

  // the extra edge lets the checker queue the last transfer before we look
  task automatic wait_for_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (chk_waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_palette_size(input logic [8:0] size);
    cfg_valid <= 1'b1;
    cfg_data  <= size;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    sizes_written++;
  endtask

  function automatic logic [7:0] extreme_component();
    return $urandom_range(0, 1) ? 8'hFF : 8'h00;
  endfunction

  task automatic pick_entry_colour(output logic [7:0] r, g, b);
    int unsigned sel, j;
    sel = $urandom_range(0, 9);
    j   = $urandom_range(0, 255);
    if (sel < 2 && loaded[j]) begin
      // duplicate colours make ties between entries
      {r, g, b} = colour_shadow[j];
    end else if (sel == 2) begin
      r = extreme_component();
      g = extreme_component();
      b = extreme_component();
    end else begin
      r = 8'($urandom());
      g = 8'($urandom());
      b = 8'($urandom());
    end
  endtask

  task automatic pick_pixel(input int unsigned span, output logic [7:0] r, g, b);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 3 && span != 0) begin
      {r, g, b} = colour_shadow[8'($urandom_range(0, span - 1))];
      // nudge one component off an exact hit now and then
      if (sel == 2) r = (r == 8'hFF) ? r - 8'd1 : r + 8'd1;
    end else if (sel == 3) begin
      r = extreme_component();
      g = extreme_component();
      b = extreme_component();
    end else begin
      r = 8'($urandom());
      g = 8'($urandom());
      b = 8'($urandom());
    end
  endtask

  initial begin : stimulus
    logic [8:0]  size;
    int unsigned span, sel, phase;
    logic [7:0]  idx, r, g, b;

    burst = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // empty palette straight out of reset, then a few fixed entries
    offer_item(OP_CLASSIFY, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    offer_item(OP_CLASSIFY, 8'h00, 8'h00, 8'h00, 8'h00);
    offer_item(OP_LOAD, 8'd0, 8'h00, 8'h00, 8'h00);
    offer_item(OP_LOAD, 8'd1, 8'hFF, 8'hFF, 8'hFF);
    offer_item(OP_LOAD, 8'd2, 8'hF0, 8'h10, 8'h08);
    offer_item(OP_LOAD, 8'd3, 8'h00, 8'h00, 8'h00);
    offer_item(OP_LOAD, 8'd4, 8'h00, 8'hFF, 8'h00);
    offer_item(OP_LOAD, 8'd255, 8'h55, 8'hAA, 8'h5A);
    wait_for_idle();

    // single entry: largest possible distance and an exact hit
    write_palette_size(9'd1);
    offer_item(OP_CLASSIFY, 8'h80, 8'hFF, 8'hFF, 8'hFF);
    offer_item(OP_CLASSIFY, 8'h7F, 8'h00, 8'h00, 8'h00);
    wait_for_idle();

    // five entries: tie on black goes to the lower slot until slot 0 moves
    write_palette_size(9'd5);
    offer_item(OP_CLASSIFY, 8'h01, 8'h00, 8'h00, 8'h00);
    offer_item(OP_CLASSIFY, 8'h02, 8'hFF, 8'hFF, 8'hFF);
    offer_item(OP_CLASSIFY, 8'h04, 8'hC8, 8'h14, 8'h0A);
    offer_item(OP_CLASSIFY, 8'h08, 8'h80, 8'h80, 8'h80);
    offer_item(OP_LOAD, 8'd0, 8'h01, 8'h01, 8'h01);
    offer_item(OP_CLASSIFY, 8'h10, 8'h00, 8'h00, 8'h00);
    offer_item(OP_CLASSIFY, 8'h20, 8'h00, 8'hFE, 8'h01);
    wait_for_idle();

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        0: size = 9'd256;
        1: size = 9'd511;
        2: size = 9'd0;
        3: size = 9'd1;
        default: begin
          sel = $urandom_range(0, 11);
          if (sel == 0) size = 9'd0;
          else if (sel <= 2) size = 9'($urandom_range(256, 511));
          else size = 9'($urandom_range(1, 24));
        end
      endcase
      span = (size > 9'd256) ? 256 : size;
      write_palette_size(size);

      // every entry the search reads must hold a colour first
      for (int unsigned j = 0; j < span; j++) begin
        if (!loaded[j]) begin
          pick_entry_colour(r, g, b);
          offer_item(OP_LOAD, j[7:0], r, g, b);
        end
      end

      burst = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 99) < 65) begin
          pick_pixel(span, r, g, b);
          offer_item(OP_CLASSIFY, 8'($urandom()), r, g, b);
        end else begin
          if (span != 0 && $urandom_range(0, 1)) idx = 8'($urandom_range(0, span - 1));
          else idx = 8'($urandom_range(0, 255));
          pick_entry_colour(r, g, b);
          offer_item(OP_LOAD, idx, r, g, b);
        end
      end
      burst = 1'b0;
      wait_for_idle();
      phase++;
    end

    $display("covered %0d loads and %0d pixel lookups over %0d palette sizes",
             chk_loads, chk_lookups, sizes_written);
    $display("sizes included empty, one entry, full and oversized; %0d results checked",
             chk_results);
    if (chk_mismatches == 0 && chk_waiting == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : receiver
    int unsigned hold;
    int          taken;
    taken = 0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      // one long hold-off so the block fills and stalls its input
      if (taken == HOLD_AT) hold = HOLD_CYCLES;
      else if ((taken / 40) % 3 == 1) hold = 0;
      else hold = $urandom_range(0, MAX_GAP);
      if (hold != 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (out_tvalid !== 1'b1) @(posedge clk);
      taken++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

endmodule

`default_nettype wire

>>> files.f
+incdir+sv
sv/npc_pkg.sv
sv/npc_palette_mem.sv
sv/npc_dist_unit.sv
sv/nearest_palette_color.sv
tb/npc_checker.sv
tb/tb.sv
